FILE: rtl/sbd_pkg.sv
// Shared types, constants and helper functions of the soft brush dab stamp.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package sbd_pkg;

    localparam int MAX_BRUSH = 128;
    localparam int MAX_DIM   = 2048;

    localparam int DIV_STEPS = 16;   // quotient bits of each divider
    localparam int DIV_W     = 20;   // divisor and remainder width
    localparam int N_W       = 14;   // width of dx*dx + dy*dy
    localparam int RR_W      = 13;   // width of r*r
    localparam int R_W       = 7;    // width of the radius
    localparam int OPA_W     = 17;   // falloff in Q16, may exceed 1.0

    typedef enum logic [2:0] {
        CFG_DIAMETER = 3'd0,
        CFG_HARDNESS = 3'd1,
        CFG_OPACITY  = 3'd2,
        CFG_ERASE    = 3'd3,
        CFG_WIDTH    = 3'd4,
        CFG_HEIGHT   = 3'd5
    } cfg_idx_t;

    // Falloff branch of one pixel.
    typedef enum logic [1:0] {
        CLS_ZERO  = 2'd0,   // outside the circle, or the undefined split
        CLS_DN    = 2'd1,   // inner part, hardness up to 100 percent
        CLS_UP    = 2'd2,   // inner part, hardness above 100 percent
        CLS_OUTER = 2'd3    // outer part of the falloff
    } cls_t;

    // Side band that travels with an item through the dividers.
    typedef struct packed {
        logic             stamp;
        logic [7:0]       old;
        cls_t             cls;
        logic [N_W-1:0]   n;
        logic [OPA_W-1:0] opa;
    } sb_t;

    function automatic logic [R_W-1:0] radius(input logic [7:0] diameter);
        logic [7:0] d;
        begin
            d = (diameter > 8'(MAX_BRUSH)) ? 8'(MAX_BRUSH) : diameter;
            radius = d[7:1];
        end
    endfunction

    function automatic logic [RR_W-1:0] radius_sq(input logic [7:0] diameter);
        logic [R_W-1:0] r;
        begin
            r = radius(diameter);
            radius_sq = RR_W'(r) * RR_W'(r);
        end
    endfunction

    function automatic logic [11:0] sat_dim(input logic [11:0] dim);
        begin
            sat_dim = (dim > 12'(MAX_DIM)) ? 12'(MAX_DIM) : dim;
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/soft_brush_dab_stamp.sv
// Soft round brush dab stamp: one mask pixel in, its new 8-bit value out.
// Pixels pass the front end, the two 16-stage pipelined dividers and the back
// end into the output register; one pixel is accepted every cycle.
// The whole pipeline moves together and holds while the output is stalled.
// Reset (rst_n low, asynchronous) empties the pipeline and loads the register
// defaults: diameter 1, hardness 0, opacity 255, paint, 2048 by 2048 image.
`timescale 1ns / 1ps
`default_nettype none

module soft_brush_dab_stamp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [10:0]        pixel_x,
    input  wire logic [10:0]        pixel_y,
    input  wire logic signed [12:0] center_x,
    input  wire logic signed [12:0] center_y,
    input  wire logic [7:0]         old_value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [7:0]              new_value,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [11:0]        cfg_data
);
    import sbd_pkg::*;

    // Configuration registers.
    logic [7:0]  diameter_reg;
    logic [6:0]  hardness_reg;
    logic [7:0]  opacity_reg;
    logic        erase_reg;
    logic [11:0] width_reg;
    logic [11:0] height_reg;

    // The pipeline advances whenever the output register is free or drains.
    logic en;

    logic             f_valid;
    logic [DIV_W-1:0] f_hi;
    logic [DIV_W-1:0] f_den;
    sb_t              f_sb;

    logic                 d1_valid;
    logic [DIV_STEPS-1:0] d1_q;
    sb_t                  d1_sb;

    logic             m1_valid_reg;
    sb_t              m1_sb_reg;
    logic [OPA_W-1:0] opa_c;
    sb_t              m1_sb_c;

    logic                 m2_valid_reg;
    logic [DIV_W-1:0]     m2_hi_reg;
    logic [DIV_STEPS-1:0] m2_lo_reg;
    logic [DIV_W-1:0]     m2_den_reg;
    sb_t                  m2_sb_reg;
    logic [29:0]          prod_c;

    logic                 d2_valid;
    logic [DIV_STEPS-1:0] d2_q;
    sb_t                  d2_sb;

    assign en        = !out_valid || !out_stall;
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diameter_reg <= 8'd1;
            hardness_reg <= 7'd0;
            opacity_reg  <= 8'd255;
            erase_reg    <= 1'b0;
            width_reg    <= 12'(MAX_DIM);
            height_reg   <= 12'(MAX_DIM);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DIAMETER: diameter_reg <= cfg_data[7:0];
                CFG_HARDNESS: hardness_reg <= cfg_data[6:0];
                CFG_OPACITY:  opacity_reg  <= cfg_data[7:0];
                CFG_ERASE:    erase_reg    <= cfg_data[0];
                CFG_WIDTH:    width_reg    <= cfg_data;
                CFG_HEIGHT:   height_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Geometry, squared distance and the falloff ratio operands.
    sbd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .center_x  (center_x),
        .center_y  (center_y),
        .old_value (old_value),
        .diameter  (diameter_reg),
        .hardness  (hardness_reg),
        .width     (width_reg),
        .height    (height_reg),
        .out_valid (f_valid),
        .out_hi    (f_hi),
        .out_den   (f_den),
        .out_sb    (f_sb)
    );

    // Falloff ratio in Q16.
    sbd_divider u_div_falloff (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_hi     (f_hi),
        .in_lo     ('0),
        .in_den    (f_den),
        .in_sb     (f_sb),
        .out_valid (d1_valid),
        .out_q     (d1_q),
        .out_sb    (d1_sb)
    );

    // Falloff value from the branch and the ratio.
    always_comb
    begin
        unique case (d1_sb.cls)
            CLS_DN:    opa_c = OPA_W'(65536) - OPA_W'(d1_q);
            CLS_UP:    opa_c = OPA_W'(65536) + OPA_W'(d1_q);
            CLS_OUTER: opa_c = OPA_W'(d1_q);
            default:   opa_c = '0;
        endcase
        m1_sb_c     = d1_sb;
        m1_sb_c.opa = opa_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m1_valid_reg <= d1_valid;
            m2_valid_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_sb_reg <= m1_sb_c;
        end
    end

    // Boost term opa * n / (2 r^2). Outside the circle opa is zero, and
    // inside n stays within r^2, so the product fits in 30 bits.
    assign prod_c = 30'(m1_sb_reg.opa) * 30'(m1_sb_reg.n);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m2_hi_reg  <= DIV_W'(prod_c[29:16]);
            m2_lo_reg  <= prod_c[15:0];
            m2_den_reg <= DIV_W'({radius_sq(diameter_reg), 1'b0});
            m2_sb_reg  <= m1_sb_reg;
        end
    end

    sbd_divider u_div_boost (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (m2_valid_reg),
        .in_hi     (m2_hi_reg),
        .in_lo     (m2_lo_reg),
        .in_den    (m2_den_reg),
        .in_sb     (m2_sb_reg),
        .out_valid (d2_valid),
        .out_q     (d2_q),
        .out_sb    (d2_sb)
    );

    // Opacity scaling, clamp, snap and merge with the old value.
    sbd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d2_valid),
        .in_q      (d2_q),
        .in_sb     (d2_sb),
        .opacity   (opacity_reg),
        .erase     (erase_reg),
        .out_valid (out_valid),
        .new_value (new_value)
    );

endmodule

`default_nettype wire

FILE: rtl/sbd_front.sv
// Front end of the dab stamp: bounds checks, squared distance, falloff branch
// and the dividend and divisor of the falloff ratio. Uses sbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbd_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire logic [10:0]               pixel_x,
    input  wire logic [10:0]               pixel_y,
    input  wire logic signed [12:0]        center_x,
    input  wire logic signed [12:0]        center_y,
    input  wire logic [7:0]                old_value,
    input  wire logic [7:0]                diameter,
    input  wire logic [6:0]                hardness,
    input  wire logic [11:0]               width,
    input  wire logic [11:0]               height,
    output logic                           out_valid,
    output logic [sbd_pkg::DIV_W-1:0]      out_hi,
    output logic [sbd_pkg::DIV_W-1:0]      out_den,
    output sbd_pkg::sb_t                   out_sb
);
    import sbd_pkg::*;

    logic [R_W-1:0]      r;
    logic [RR_W-1:0]     rr;
    logic [11:0]         w_sat;
    logic [11:0]         h_sat;
    logic signed [13:0]  dx_c;
    logic signed [13:0]  dy_c;
    logic signed [13:0]  rs;
    logic                stamp_c;

    logic                v1_reg;
    logic                stamp1_reg;
    logic [7:0]          old1_reg;
    logic signed [7:0]   dx1_reg;
    logic signed [7:0]   dy1_reg;

    logic [R_W-1:0]      adx;
    logic [R_W-1:0]      ady;
    logic [N_W-1:0]      n_c;
    logic [20:0]         n100;
    logic [19:0]         hrr;
    cls_t                cls_c;

    logic                v2_reg;
    logic                stamp2_reg;
    logic [7:0]          old2_reg;
    logic [N_W-1:0]      n2_reg;
    cls_t                cls2_reg;

    logic [RR_W-1:0]     rmn;
    logic [DIV_W-1:0]    hi_c;
    logic [DIV_W-1:0]    den_c;

    always_comb
    begin
        r     = radius(diameter);
        rr    = radius_sq(diameter);
        w_sat = sat_dim(width);
        h_sat = sat_dim(height);
        rs    = $signed({7'd0, r});
        dx_c  = $signed({3'd0, pixel_x}) - $signed({center_x[12], center_x});
        dy_c  = $signed({3'd0, pixel_y}) - $signed({center_y[12], center_y});
        stamp_c = (r != '0)
                && !center_x[12] && !center_y[12]
                && (center_x <= $signed({1'b0, w_sat}))
                && (center_y <= $signed({1'b0, h_sat}))
                && ({1'b0, pixel_x} < w_sat) && ({1'b0, pixel_y} < h_sat)
                && (dx_c >= -rs) && (dx_c < rs)
                && (dy_c >= -rs) && (dy_c < rs);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stamp1_reg <= stamp_c;
            old1_reg   <= old_value;
            dx1_reg    <= dx_c[7:0];
            dy1_reg    <= dy_c[7:0];
        end
    end

    // Squared distance and falloff branch.
    always_comb
    begin
        adx  = dx1_reg[7] ? R_W'(-dx1_reg) : dx1_reg[R_W-1:0];
        ady  = dy1_reg[7] ? R_W'(-dy1_reg) : dy1_reg[R_W-1:0];
        n_c  = N_W'(adx) * N_W'(adx) + N_W'(ady) * N_W'(ady);
        n100 = 21'(n_c) * 21'd100;
        hrr  = 20'(hardness) * 20'(rr);
        if (n_c > N_W'(rr))
        begin
            cls_c = CLS_ZERO;
        end
        else if (n100 < {1'b0, hrr})
        begin
            cls_c = (hardness <= 7'd100) ? CLS_DN : CLS_UP;
        end
        else if (hardness < 7'd100)
        begin
            cls_c = CLS_OUTER;
        end
        else
        begin
            cls_c = CLS_ZERO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stamp2_reg <= stamp1_reg;
            old2_reg   <= old1_reg;
            n2_reg     <= n_c;
            cls2_reg   <= cls_c;
        end
    end

    // Dividend (before the 16 fraction bits) and divisor of the falloff.
    always_comb
    begin
        rmn = rr - n2_reg[RR_W-1:0];
        unique case (cls2_reg)
            CLS_DN:
            begin
                hi_c  = DIV_W'(n2_reg) * DIV_W'(7'd100 - hardness);
                den_c = DIV_W'(hardness) * DIV_W'(rr);
            end
            CLS_UP:
            begin
                hi_c  = DIV_W'(n2_reg) * DIV_W'(hardness - 7'd100);
                den_c = DIV_W'(hardness) * DIV_W'(rr);
            end
            CLS_OUTER:
            begin
                hi_c  = DIV_W'(hardness) * DIV_W'(rmn);
                den_c = DIV_W'(7'd100 - hardness) * DIV_W'(rr);
            end
            default:
            begin
                hi_c  = '0;
                den_c = DIV_W'(1);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            out_valid <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_hi  <= hi_c;
            out_den <= den_c;
            out_sb  <= '{stamp: stamp2_reg, old: old2_reg, cls: cls2_reg,
                         n: n2_reg, opa: '0};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sbd_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with side band.
// The high dividend part must be below the divisor. Uses sbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbd_divider (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [sbd_pkg::DIV_W-1:0]     in_hi,
    input  wire logic [sbd_pkg::DIV_STEPS-1:0] in_lo,
    input  wire logic [sbd_pkg::DIV_W-1:0]     in_den,
    input  wire sbd_pkg::sb_t                  in_sb,
    output logic                               out_valid,
    output logic [sbd_pkg::DIV_STEPS-1:0]      out_q,
    output sbd_pkg::sb_t                       out_sb
);
    import sbd_pkg::*;

    logic                 v_reg   [DIV_STEPS];
    logic [DIV_W-1:0]     rem_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] lo_reg  [DIV_STEPS];
    logic [DIV_STEPS-1:0] q_reg   [DIV_STEPS];
    logic [DIV_W-1:0]     den_reg [DIV_STEPS];
    sb_t                  sb_reg  [DIV_STEPS];

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++)
        begin : g_step
            logic                 pv;
            logic [DIV_W-1:0]     prem;
            logic [DIV_STEPS-1:0] plo;
            logic [DIV_STEPS-1:0] pq;
            logic [DIV_W-1:0]     pden;
            sb_t                  psb;
            logic [DIV_W:0]       trial;
            logic                 ge;
            logic [DIV_W-1:0]     rem_next;

            if (k == 0)
            begin : g_first
                assign pv   = in_valid;
                assign prem = in_hi;
                assign plo  = in_lo;
                assign pq   = '0;
                assign pden = in_den;
                assign psb  = in_sb;
            end
            else
            begin : g_next
                assign pv   = v_reg[k-1];
                assign prem = rem_reg[k-1];
                assign plo  = lo_reg[k-1];
                assign pq   = q_reg[k-1];
                assign pden = den_reg[k-1];
                assign psb  = sb_reg[k-1];
            end

            always_comb
            begin
                trial    = {prem, plo[DIV_STEPS-1]};
                ge       = trial >= {1'b0, pden};
                rem_next = ge ? DIV_W'(trial - {1'b0, pden}) : trial[DIV_W-1:0];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[k] <= pv;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                    lo_reg[k]  <= {plo[DIV_STEPS-2:0], 1'b0};
                    q_reg[k]   <= {pq[DIV_STEPS-2:0], ge};
                    den_reg[k] <= pden;
                    sb_reg[k]  <= psb;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[DIV_STEPS-1];
    assign out_q     = q_reg[DIV_STEPS-1];
    assign out_sb    = sb_reg[DIV_STEPS-1];

endmodule

`default_nettype wire

FILE: rtl/sbd_back.sv
// Back end of the dab stamp: boost, opacity scaling, clamp and snap, and the
// paint or erase merge into the output register. Uses sbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbd_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [sbd_pkg::DIV_STEPS-1:0] in_q,
    input  wire sbd_pkg::sb_t                  in_sb,
    input  wire logic [7:0]                    opacity,
    input  wire logic                          erase,
    output logic                               out_valid,
    output logic [7:0]                         new_value
);
    import sbd_pkg::*;

    logic [OPA_W-1:0] boost;
    logic             v1_reg;
    logic             stamp1_reg;
    logic [7:0]       old1_reg;
    logic [24:0]      pv1_reg;

    logic [24:0]      full;
    logic [24:0]      knee;
    logic [24:0]      pv_c;
    logic [7:0]       dab;
    logic [7:0]       inv;
    logic [7:0]       res;

    assign boost = in_sb.opa + OPA_W'(in_q);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stamp1_reg <= in_sb.stamp;
            old1_reg   <= in_sb.old;
            pv1_reg    <= 25'(boost) * 25'(opacity);
        end
    end

    // Clamp to full opacity, then snap to full within four steps of it or when opacity is below four.
    always_comb
    begin
        full = {1'b0, opacity, 16'd0};
        knee = {1'b0, 8'(opacity - 8'd4), 16'd0};
        pv_c = (pv1_reg > full) ? full : pv1_reg;
        if ((opacity < 8'd4) || (pv_c > knee))
        begin
            pv_c = full;
        end
        dab = pv_c[23:16];
        inv = 8'd255 - dab;
        if (!stamp1_reg)
        begin
            res = old1_reg;
        end
        else if (erase)
        begin
            res = (inv < old1_reg) ? inv : old1_reg;
        end
        else
        begin
            res = (dab > old1_reg) ? dab : old1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            out_valid <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            new_value <= res;
        end
    end

endmodule

`default_nettype wire

FILE: bench/soft_brush_dab_stamp_tb.sv
// Self-checking testbench of the soft brush dab stamp: a directed table, then random pixels.
// Every result is checked against a predictor of the dab falloff.
// Depends on sbd_pkg and the soft_brush_dab_stamp RTL.
`timescale 1ns / 1ps

module soft_brush_dab_stamp_tb;
    import sbd_pkg::*;

    // The block has a pipeline of 39 stages; the drain wait is ample to empty it.
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DIR_N        = 18;
    localparam int RAND_PHASES  = 10;
    localparam int PHASE_PIXELS = 90;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [10:0]        pixel_x;
    logic [10:0]        pixel_y;
    logic signed [12:0] center_x;
    logic signed [12:0] center_y;
    logic [7:0]         old_value;
    logic               out_valid;
    logic               out_stall;
    logic [7:0]         new_value;
    logic               cfg_valid;
    logic               cfg_ready;
    cfg_idx_t           cfg_index;
    logic [11:0]        cfg_data;

    soft_brush_dab_stamp dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .center_x  (center_x),
        .center_y  (center_y),
        .old_value (old_value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .new_value (new_value),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // One row of the directed table: the register settings it needs, the pixel,
    // and the value read straight off the falloff rules, or -1 where the
    // predictor has to work it out.
    typedef struct {
        int dia, hard, opa, ers, wid, hgt;
        int px, py, cx, cy, old;
        int exp_value;
    } dir_row_t;

    dir_row_t dir_rows[DIR_N];

    // Register copies that the predictor uses, as written into the block.
    int unsigned reg_diameter;
    int unsigned reg_hardness;
    int unsigned reg_opacity;
    int unsigned reg_erase;
    int unsigned reg_width;
    int unsigned reg_height;

    logic [7:0] expected_values[$];
    int         mismatches;
    int         pixels_sent;
    int         pixels_checked;
    int         cfg_writes;
    int         cycles;
    int         stall_left;
    bit         stall_quiet;

    // Mask value the stamp should leave at one pixel, under the current registers.
    function automatic logic [7:0] stamp_value(int px, int py, int cx, int cy, int old);
        longint d, w, h, r, ix, iy, dx, dy;
        longint unsigned n, rr, hp, op, opa, boost, pv, full, dab;
        begin
            d = (reg_diameter > MAX_BRUSH) ? MAX_BRUSH : reg_diameter;
            w = (reg_width > MAX_DIM) ? MAX_DIM : reg_width;
            h = (reg_height > MAX_DIM) ? MAX_DIM : reg_height;
            r = d / 2;
            if (r == 0 || cx < 0 || cy < 0 || cx > w || cy > h || px >= w || py >= h)
                return old[7:0];
            ix = px - (cx - r);
            iy = py - (cy - r);
            if (ix < 0 || iy < 0 || ix >= 2 * r || iy >= 2 * r)
                return old[7:0];
            dx = ix - r;
            dy = iy - r;
            n = dx * dx + dy * dy;
            rr = r * r;
            hp = reg_hardness;
            op = reg_opacity;
            full = op << 16;
            // Falloff: zero outside the circle, linear inner part below the
            // hardness split, then the outer part down to the rim.
            if (n > rr)
                opa = 0;
            else if (100 * n < hp * rr)
                opa = (hp <= 100) ? 65536 - (n * (100 - hp) * 65536) / (hp * rr)
                                  : 65536 + (n * (hp - 100) * 65536) / (hp * rr);
            else if (hp < 100)
                opa = (hp * (rr - n) * 65536) / ((100 - hp) * rr);
            else
                opa = 0;
            boost = (opa * (2 * rr + n)) / (2 * rr);
            pv = boost * op;
            if (pv > full)
                pv = full;
            // Values within four of the peak snap to it; low opacity always snaps.
            if (op < 4)
                pv = full;
            else if (pv > ((op - 4) << 16))
                pv = full;
            dab = (pv >> 16) & 8'hFF;
            if (reg_erase != 0)
                return ((255 - dab) < old) ? 8'(255 - dab) : old[7:0];
            return (dab > old) ? dab[7:0] : old[7:0];
        end
    endfunction

    // Gap length for both sides: mostly none, some short, a few long.
    function automatic int pick_gap();
        int sel;
        begin
            sel = $urandom_range(0, 99);
            if (sel < 60)
                return 0;
            if (sel < 90)
                return $urandom_range(1, 3);
            return $urandom_range(10, 30);
        end
    endfunction

    task automatic report_mismatch(input string what);
        begin
            $display("[%0t] mismatch: %s", $realtime, what);
            mismatches++;
        end
    endtask

    // Clock with a 2 ns period.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // A cycle counter guards against a hung handshake.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_values.size());
            $display("FAILURE");
            $finish;
        end
    end

    // The output side stalls in random bursts, with quiet stretches between them
    // so that the pipeline also runs at full rate.
    always @(posedge clk)
    begin
        if (cycles % 300 == 0)
            stall_quiet = ($urandom_range(0, 2) == 0);
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (!stall_quiet && $urandom_range(0, 5) == 0)
                stall_left = pick_gap();
        end
    end

    // Each output transfer is compared with the oldest expected value.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_values.size() == 0)
                report_mismatch($sformatf("new_value %0d with nothing expected", new_value));
            else
            begin
                if (new_value !== expected_values[0])
                    report_mismatch($sformatf("new_value %0d, expected %0d",
                                              new_value, expected_values[0]));
                void'(expected_values.pop_front());
                pixels_checked++;
            end
        end
    end

    // Writes one register and keeps the predictor's copy in step.
    task automatic write_reg(input cfg_idx_t idx, input int value);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= 12'(value);
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            cfg_valid <= 1'b0;
            cfg_writes++;
            case (idx)
                CFG_DIAMETER: reg_diameter = value & 8'hFF;
                CFG_HARDNESS: reg_hardness = value & 7'h7F;
                CFG_OPACITY:  reg_opacity  = value & 8'hFF;
                CFG_ERASE:    reg_erase    = value & 1;
                CFG_WIDTH:    reg_width    = value & 12'hFFF;
                CFG_HEIGHT:   reg_height   = value & 12'hFFF;
                default: ;
            endcase
        end
    endtask

    // Registers change only once every expected value has come out and the
    // pipeline has had time to empty.
    task automatic apply_settings(input int dia, input int hard, input int opa,
                                  input int ers, input int wid, input int hgt,
                                  input bit all_regs);
        begin
            in_valid <= 1'b0;
            while (expected_values.size() != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
            if (all_regs || dia != reg_diameter) write_reg(CFG_DIAMETER, dia);
            if (all_regs || hard != reg_hardness) write_reg(CFG_HARDNESS, hard);
            if (all_regs || opa != reg_opacity) write_reg(CFG_OPACITY, opa);
            if (all_regs || ers != reg_erase) write_reg(CFG_ERASE, ers);
            if (all_regs || wid != reg_width) write_reg(CFG_WIDTH, wid);
            if (all_regs || hgt != reg_height) write_reg(CFG_HEIGHT, hgt);
        end
    endtask

    // Presents one pixel, waits for its transfer and records what must come out.
    // in_valid stays high into the next pixel when no gap follows.
    task automatic send_pixel(input int px, input int py, input int cx, input int cy,
                              input int old, input int exp_value);
        int gap;
        begin
            in_valid  <= 1'b1;
            pixel_x   <= 11'(px);
            pixel_y   <= 11'(py);
            center_x  <= 13'(cx);
            center_y  <= 13'(cy);
            old_value <= 8'(old);
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            if (exp_value >= 0)
                expected_values.push_back(8'(exp_value));
            else
                expected_values.push_back(stamp_value(px, py, cx, cy, old));
            pixels_sent++;
            gap = pick_gap();
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Random register setting for one phase, with the extremes favored.
    task automatic random_settings();
        int dia, hard, opa, wid, hgt;
        begin
            case ($urandom_range(0, 7))
                0: dia = $urandom_range(0, 1);
                1: dia = 255;
                2: dia = 128;
                3: dia = 2;
                default: dia = $urandom_range(2, 40);
            endcase
            case ($urandom_range(0, 5))
                0: hard = 0;
                1: hard = 100;
                2: hard = $urandom_range(101, 127);
                default: hard = $urandom_range(1, 99);
            endcase
            case ($urandom_range(0, 5))
                0: opa = $urandom_range(0, 4);
                1: opa = 255;
                default: opa = $urandom_range(0, 255);
            endcase
            case ($urandom_range(0, 5))
                0: wid = $urandom_range(1, 16);
                1: wid = $urandom_range(2048, 4095);
                default: wid = $urandom_range(1, 2048);
            endcase
            case ($urandom_range(0, 5))
                0: hgt = $urandom_range(1, 16);
                1: hgt = $urandom_range(2048, 4095);
                default: hgt = $urandom_range(1, 2048);
            endcase
            apply_settings(dia, hard, opa, $urandom_range(0, 1), wid, hgt, 1'b1);
        end
    endtask

    // Mostly pixels in and just around the dab square of a centre on the image,
    // the rest fully random noise over every field.
    task automatic random_pixel();
        int r, w, h, cx, cy, px, py;
        begin
            r = ((reg_diameter > MAX_BRUSH) ? MAX_BRUSH : reg_diameter) / 2;
            w = (reg_width > MAX_DIM) ? MAX_DIM : reg_width;
            h = (reg_height > MAX_DIM) ? MAX_DIM : reg_height;
            if ($urandom_range(0, 9) < 8)
            begin
                cx = $urandom_range(0, w);
                cy = $urandom_range(0, h);
                px = cx - r - 1 + $urandom_range(0, 2 * r + 2);
                py = cy - r - 1 + $urandom_range(0, 2 * r + 2);
                px = (px < 0) ? 0 : (px > 2047) ? 2047 : px;
                py = (py < 0) ? 0 : (py > 2047) ? 2047 : py;
                send_pixel(px, py, cx, cy, $urandom_range(0, 255), -1);
            end
            else
                send_pixel($urandom_range(0, 2047), $urandom_range(0, 2047),
                           $signed(13'($urandom)), $signed(13'($urandom)),
                           $urandom_range(0, 255), -1);
        end
    endtask

    initial
    begin
        // Directed rows: tiny brushes at reset, the centre peak, edges of the
        // dab square, centres off the image, erase, hardness at and above 100,
        // low opacity snapping, oversized registers and a one-pixel image.
        dir_rows[0]  = '{1, 0, 255, 0, 2048, 2048, 0, 0, 0, 0, 90, 90};
        dir_rows[1]  = '{0, 0, 255, 0, 2048, 2048, 2047, 2047, 4095, 4095, 255, 255};
        dir_rows[2]  = '{16, 50, 255, 0, 2048, 2048, 100, 100, 100, 100, 0, 255};
        dir_rows[3]  = '{16, 50, 255, 0, 2048, 2048, 108, 100, 100, 100, 7, 7};
        dir_rows[4]  = '{16, 50, 255, 0, 2048, 2048, 92, 92, 100, 100, 0, -1};
        dir_rows[5]  = '{16, 50, 255, 0, 2048, 2048, 96, 100, 100, 100, 20, -1};
        dir_rows[6]  = '{16, 50, 255, 0, 2048, 2048, 100, 100, -1, 100, 3, 3};
        dir_rows[7]  = '{16, 50, 255, 0, 2048, 2048, 100, 100, 2049, 100, 4, 4};
        dir_rows[8]  = '{16, 50, 255, 1, 2048, 2048, 100, 100, 100, 100, 200, 0};
        dir_rows[9]  = '{16, 50, 255, 1, 2048, 2048, 97, 101, 100, 100, 250, -1};
        dir_rows[10] = '{16, 100, 255, 0, 2048, 2048, 104, 100, 100, 100, 0, -1};
        dir_rows[11] = '{16, 127, 255, 0, 2048, 2048, 105, 102, 100, 100, 0, -1};
        dir_rows[12] = '{16, 0, 255, 0, 2048, 2048, 103, 99, 100, 100, 0, -1};
        dir_rows[13] = '{16, 0, 2, 0, 2048, 2048, 92, 92, 100, 100, 0, 2};
        dir_rows[14] = '{16, 0, 0, 0, 2048, 2048, 100, 100, 100, 100, 9, 9};
        dir_rows[15] = '{255, 30, 200, 0, 4095, 4095, 2047, 2047, 2047, 2047, 0, 200};
        dir_rows[16] = '{16, 30, 200, 0, 1, 1, 1, 0, 0, 0, 6, 6};
        dir_rows[17] = '{4, 0, 255, 0, 1, 1, 0, 0, 1, 1, 0, -1};

        // Every input starts at a known value, with reset held low before its release.
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        pixel_x     = '0;
        pixel_y     = '0;
        center_x    = '0;
        center_y    = '0;
        old_value   = '0;
        out_stall   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_DIAMETER;
        cfg_data    = '0;
        cycles      = 0;
        stall_left  = 0;
        stall_quiet = 1'b0;
        mismatches  = 0;
        reg_diameter = 1;
        reg_hardness = 0;
        reg_opacity  = 255;
        reg_erase    = 0;
        reg_width    = 2048;
        reg_height   = 2048;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].dia != reg_diameter || dir_rows[i].hard != reg_hardness ||
                dir_rows[i].opa != reg_opacity || dir_rows[i].ers != reg_erase ||
                dir_rows[i].wid != reg_width || dir_rows[i].hgt != reg_height)
                apply_settings(dir_rows[i].dia, dir_rows[i].hard, dir_rows[i].opa,
                               dir_rows[i].ers, dir_rows[i].wid, dir_rows[i].hgt, 1'b0);
            send_pixel(dir_rows[i].px, dir_rows[i].py, dir_rows[i].cx, dir_rows[i].cy,
                       dir_rows[i].old, dir_rows[i].exp_value);
        end

        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            in_valid <= 1'b0;
            random_settings();
            repeat (PHASE_PIXELS) random_pixel();
        end
        in_valid <= 1'b0;

        while (expected_values.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Stamped %0d pixels (%0d checked) over %0d register writes, paint and erase.",
                 pixels_sent, pixels_checked, cfg_writes);
        $display("Mismatches found: %0d.", mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
